>>> rtl/elastic_green_tensor_unit_assert.svh
// ----------------------------------------------------------------------------
// elastic_green_tensor_unit_assert.svh
// Assertion macros for the elastic Green tensor unit
// ----------------------------------------------------------------------------
`ifndef ELASTIC_GREEN_TENSOR_UNIT_ASSERT_SVH
`define ELASTIC_GREEN_TENSOR_UNIT_ASSERT_SVH

`ifndef SYNTH
// same-cycle implication
`define EGT_ASSERT_IMPLY(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("assertion failed: label");
// next-cycle implication
`define EGT_ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("assertion failed: label");
`else
`define EGT_ASSERT_IMPLY(label, clk, rst, a, b)
`define EGT_ASSERT_NEXT(label, clk, rst, a, b)
`endif

`endif

>>> rtl/egt_pkg.sv
// ----------------------------------------------------------------------------
// egt_pkg
// Types and constants shared by the elastic Green tensor unit
// ----------------------------------------------------------------------------
package egt_pkg;

  // item modes
  typedef enum logic [1:0] {
    MODE_LOAD_C = 2'd0,
    MODE_LOAD_M = 2'd1,
    MODE_GREEN  = 2'd2,
    MODE_STRESS = 2'd3
  } mode_t;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_QRD,
    ST_QM1,
    ST_QM2,
    ST_COF1,
    ST_COF2,
    ST_DET,
    ST_GDIV,
    ST_GWAIT,
    ST_SRD,
    ST_SMAC
  } state_t;

  localparam int unsigned C_DEPTH = 81;
  localparam int unsigned M_DEPTH = 9;

  typedef struct packed {
    logic [1:0]         mode;
    logic [6:0]         entry_index;
    logic signed [31:0] entry_value;
    logic signed [31:0] dir_x;
    logic signed [31:0] dir_y;
    logic signed [31:0] dir_z;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         row;
    logic [1:0]         column;
    logic signed [31:0] result_value;
    logic               singular;
    logic               last;
  } out_item_t;

  // increment modulo three
  function automatic logic [1:0] inc3(input logic [1:0] x);
    return (x == 2'd2) ? 2'd0 : x + 2'd1;
  endfunction

endpackage

>>> rtl/egt_mac.sv
// ----------------------------------------------------------------------------
// egt_mac
// Shared fixed point multiply with saturating accumulate or subtract
// ----------------------------------------------------------------------------
module egt_mac #(
  parameter int VALUE_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  logic signed [VALUE_WIDTH-1:0] a,
  input  logic signed [VALUE_WIDTH-1:0] b,
  input  logic signed [VALUE_WIDTH-1:0] c,
  input  logic                          sub,
  output logic signed [VALUE_WIDTH-1:0] r
);
  localparam int W = VALUE_WIDTH;
  localparam logic signed [2*W-1:0] PMAX = {{(W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [2*W-1:0] PMIN = {{(W+1){1'b1}}, {(W-1){1'b0}}};
  localparam logic signed [W:0]     SMAX = {2'b00, {(W-1){1'b1}}};
  localparam logic signed [W:0]     SMIN = {2'b11, {(W-1){1'b0}}};

  logic signed [2*W-1:0] prod;
  logic signed [2*W-1:0] prod_sh;
  logic signed [W-1:0]   p;
  logic signed [W:0]     s;

  // product, floored then saturated
  always_comb begin
    prod    = (2*W)'(a) * (2*W)'(b);
    prod_sh = prod >>> FRAC_BITS;
    if (prod_sh > PMAX) begin
      p = PMAX[W-1:0];
    end else if (prod_sh < PMIN) begin
      p = PMIN[W-1:0];
    end else begin
      p = prod_sh[W-1:0];
    end
  end

  // saturating add or subtract
  always_comb begin
    if (sub) begin
      s = (W+1)'(c) - (W+1)'(p);
    end else begin
      s = (W+1)'(c) + (W+1)'(p);
    end
    if (s > SMAX) begin
      r = SMAX[W-1:0];
    end else if (s < SMIN) begin
      r = SMIN[W-1:0];
    end else begin
      r = s[W-1:0];
    end
  end

endmodule

>>> rtl/egt_div.sv
// ----------------------------------------------------------------------------
// egt_div
// Restoring fixed point divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module egt_div #(
  parameter int VALUE_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic signed [VALUE_WIDTH-1:0] num,
  input  logic signed [VALUE_WIDTH-1:0] den,
  output logic                          done,
  output logic signed [VALUE_WIDTH-1:0] quo
);
  localparam int W  = VALUE_WIDTH;
  localparam int N  = VALUE_WIDTH + FRAC_BITS;
  localparam int CW = $clog2(N + 1);
  localparam logic [N-1:0] LIM = N'({1'b0, {(W-1){1'b1}}});

  logic          running;
  logic [CW-1:0] cnt;
  logic [N-1:0]  dvd;
  logic [W-1:0]  rem;
  logic [N-1:0]  quo_m;
  logic [W-1:0]  dmag;
  logic          neg;
  logic [W:0]    rem_sh;
  logic          qbit;

  function automatic logic [W-1:0] mag(input logic signed [W-1:0] x);
    return x[W-1] ? W'(-x) : W'(x);
  endfunction

  // trial subtract
  always_comb begin
    rem_sh = {rem, dvd[N-1]};
    qbit   = (rem_sh >= {1'b0, dmag});
  end

  // iteration control
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= !start && running && (cnt == CW'(1));
      if (start) begin
        running <= 1'b1;
        cnt     <= CW'(N);
      end else if (running) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          running <= 1'b0;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      dvd   <= {mag(num), {FRAC_BITS{1'b0}}};
      rem   <= '0;
      quo_m <= '0;
      dmag  <= mag(den);
      neg   <= num[W-1] ^ den[W-1];
    end else if (running) begin
      rem   <= qbit ? W'(rem_sh - {1'b0, dmag}) : rem_sh[W-1:0];
      quo_m <= {quo_m[N-2:0], qbit};
      dvd   <= {dvd[N-2:0], 1'b0};
    end
  end

  // sign and saturation
  always_comb begin
    if (!neg) begin
      quo = (quo_m > LIM) ? {1'b0, {(W-1){1'b1}}} : quo_m[W-1:0];
    end else begin
      quo = (quo_m > LIM + N'(1)) ? {1'b1, {(W-1){1'b0}}} : W'(-quo_m[W-1:0]);
    end
  end

  `include "elastic_green_tensor_unit_assert.svh"

  `EGT_ASSERT_IMPLY(a_no_start_running, clk, rst, running, !start)
  `EGT_ASSERT_NEXT(a_done_ends_run, clk, rst, done, !running)
  `EGT_ASSERT_IMPLY(a_done_idle, clk, rst, done, cnt == '0)

endmodule

>>> rtl/elastic_green_tensor_unit.sv
// ----------------------------------------------------------------------------
// elastic_green_tensor_unit
// Stiffness tensor store with acoustic tensor inversion and stress contraction
// ----------------------------------------------------------------------------
// channel   direction  handshake            payload
// request   in         start & !busy        egt_pkg::in_item_t
// result    out        strobe, one cycle    egt_pkg::out_item_t
//
// load items are stored when accepted and leave busy low
// stress item: a read and an accumulate step per term on the shared
//   multiply-accumulate unit; green item: the acoustic tensor, cofactors and
//   the determinant on that unit, then the divider for each entry
// rst clears the stores and the sequencer; no clearing pass is needed
// results cannot be stalled; each is on the port for one cycle
// ----------------------------------------------------------------------------
module elastic_green_tensor_unit #(
  parameter int VALUE_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  egt_pkg::in_item_t  request,
  output logic               strobe,
  output egt_pkg::out_item_t result
);
  import egt_pkg::*;

  localparam int W  = VALUE_WIDTH;
  localparam int XW = (VALUE_WIDTH > 32) ? VALUE_WIDTH : 32;
  localparam logic signed [XW-1:0] VMAX_X = {{(XW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [XW-1:0] VMIN_X = {{(XW-W+1){1'b1}}, {(W-1){1'b0}}};

  state_t state, state_next;

  logic signed [W-1:0] cmem [C_DEPTH];
  logic [C_DEPTH-1:0]  cvalid;
  logic signed [W-1:0] rdata;
  logic                rvalid;
  logic signed [W-1:0] cval;
  logic [6:0]          addr;

  logic signed [W-1:0] mis [3][3];
  logic signed [W-1:0] q   [3][3];
  logic signed [W-1:0] cof [3][3];
  logic signed [W-1:0] n   [3];
  logic signed [W-1:0] acc;
  logic signed [W-1:0] tmp;
  logic signed [W-1:0] det;
  logic [1:0]          ra, rb, ta, tb;
  logic                last_term, last_ent;

  logic signed [W-1:0] mac_a, mac_b, mac_c, mac_r;
  logic                mac_sub;
  logic                div_start, div_done;
  logic signed [W-1:0] div_q;
  logic                accept;

  function automatic logic signed [W-1:0] in_conv(input logic signed [31:0] x);
    logic signed [XW-1:0] xe;
    xe = XW'(x);
    if (xe > VMAX_X) return VMAX_X[W-1:0];
    if (xe < VMIN_X) return VMIN_X[W-1:0];
    return xe[W-1:0];
  endfunction

  function automatic logic signed [31:0] out_conv(input logic signed [W-1:0] v);
    logic signed [XW-1:0] ve;
    ve = XW'(v);
    return ve[31:0];
  endfunction

  assign accept    = start && !busy;
  assign busy      = (state != ST_IDLE);
  assign last_term = (ta == 2'd2) && (tb == 2'd2);
  assign last_ent  = (ra == 2'd2) && (rb == 2'd2);
  assign cval      = rvalid ? rdata : '0;

  // shared units
  egt_mac #(.VALUE_WIDTH(W), .FRAC_BITS(FRAC_BITS)) u_mac (
    .a(mac_a), .b(mac_b), .c(mac_c), .sub(mac_sub), .r(mac_r)
  );

  egt_div #(.VALUE_WIDTH(W), .FRAC_BITS(FRAC_BITS)) u_div (
    .clk(clk), .rst(rst), .start(div_start),
    .num(cof[rb][ra]), .den(det), .done(div_done), .quo(div_q)
  );

  // stiffness memory, registered read
  always_ff @(posedge clk) begin
    if (accept && request.mode == MODE_LOAD_C && request.entry_index < 7'(C_DEPTH)) begin
      cmem[request.entry_index] <= in_conv(request.entry_value);
    end
    rdata  <= cmem[addr];
    rvalid <= cvalid[addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cvalid <= '0;
    end else if (accept && request.mode == MODE_LOAD_C &&
                 request.entry_index < 7'(C_DEPTH)) begin
      cvalid[request.entry_index] <= 1'b1;
    end
  end

  // misfit store
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < 3; k++) begin
        for (int l = 0; l < 3; l++) begin
          mis[k][l] <= '0;
        end
      end
    end else if (accept && request.mode == MODE_LOAD_M &&
                 request.entry_index < 7'(M_DEPTH)) begin
      for (int k = 0; k < 3; k++) begin
        for (int l = 0; l < 3; l++) begin
          if (request.entry_index == 7'(k * 3 + l)) begin
            mis[k][l] <= in_conv(request.entry_value);
          end
        end
      end
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && request.mode == MODE_GREEN) state_next = ST_QRD;
        else if (accept && request.mode == MODE_STRESS) state_next = ST_SRD;
      end
      ST_QRD:  state_next = ST_QM1;
      ST_QM1:  state_next = ST_QM2;
      ST_QM2:  state_next = (last_term && last_ent) ? ST_COF1 : ST_QRD;
      ST_COF1: state_next = ST_COF2;
      ST_COF2: state_next = last_ent ? ST_DET : ST_COF1;
      ST_DET:  state_next = (rb == 2'd2) ? ST_GDIV : ST_DET;
      ST_GDIV: begin
        if (det != '0) state_next = ST_GWAIT;
        else if (last_ent) state_next = ST_IDLE;
      end
      ST_GWAIT: begin
        if (div_done) state_next = last_ent ? ST_IDLE : ST_GDIV;
      end
      ST_SRD:  state_next = ST_SMAC;
      ST_SMAC: begin
        if (last_term) state_next = last_ent ? ST_IDLE : ST_SRD;
        else state_next = ST_SRD;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // unit operands and memory address
  always_comb begin
    mac_a     = '0;
    mac_b     = '0;
    mac_c     = '0;
    mac_sub   = 1'b0;
    div_start = 1'b0;
    addr      = 7'(ra) * 7'd27 + 7'(ta) * 7'd9 + 7'(tb) * 7'd3 + 7'(rb);
    case (state)
      ST_QM1: begin
        mac_a = cval;
        mac_b = n[ta];
      end
      ST_QM2: begin
        mac_a = tmp;
        mac_b = n[tb];
        mac_c = acc;
      end
      ST_COF1: begin
        mac_a = q[inc3(ra)][inc3(rb)];
        mac_b = q[inc3(inc3(ra))][inc3(inc3(rb))];
      end
      ST_COF2: begin
        mac_a   = q[inc3(ra)][inc3(inc3(rb))];
        mac_b   = q[inc3(inc3(ra))][inc3(rb)];
        mac_c   = tmp;
        mac_sub = 1'b1;
      end
      ST_DET: begin
        mac_a = q[0][rb];
        mac_b = cof[0][rb];
        mac_c = acc;
      end
      ST_GDIV: begin
        div_start = (det != '0);
      end
      ST_SRD: begin
        addr = 7'(ra) * 7'd27 + 7'(rb) * 7'd9 + 7'(ta) * 7'd3 + 7'(tb);
      end
      ST_SMAC: begin
        mac_a = cval;
        mac_b = mis[ta][tb];
        mac_c = acc;
      end
      default: begin
        mac_a = '0;
      end
    endcase
  end

  // state and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      strobe <= 1'b0;
      ra     <= '0;
      rb     <= '0;
      ta     <= '0;
      tb     <= '0;
    end else begin
      state  <= state_next;
      case (state)
        ST_IDLE: begin
          strobe <= 1'b0;
          ra <= '0;
          rb <= '0;
          ta <= '0;
          tb <= '0;
        end
        ST_QM2, ST_SMAC: begin
          tb <= inc3(tb);
          if (tb == 2'd2) ta <= inc3(ta);
          if (last_term) begin
            rb <= inc3(rb);
            if (rb == 2'd2) ra <= inc3(ra);
          end
          strobe <= (state == ST_SMAC) && last_term;
        end
        ST_COF2: begin
          strobe <= 1'b0;
          rb <= inc3(rb);
          if (rb == 2'd2) ra <= inc3(ra);
        end
        ST_DET: begin
          strobe <= 1'b0;
          rb <= inc3(rb);
        end
        ST_GDIV: begin
          strobe <= (det == '0);
          if (det == '0) begin
            rb <= inc3(rb);
            if (rb == 2'd2) ra <= inc3(ra);
          end
        end
        ST_GWAIT: begin
          strobe <= div_done;
          if (div_done) begin
            rb <= inc3(rb);
            if (rb == 2'd2) ra <= inc3(ra);
          end
        end
        default: begin
          strobe <= 1'b0;
        end
      endcase
    end
  end

  // datapath registers and result item
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        acc  <= '0;
        n[0] <= in_conv(request.dir_x);
        n[1] <= in_conv(request.dir_y);
        n[2] <= in_conv(request.dir_z);
      end
      ST_QM1, ST_COF1: begin
        tmp <= mac_r;
      end
      ST_QM2: begin
        if (last_term) begin
          q[ra][rb] <= mac_r;
          acc       <= '0;
        end else begin
          acc <= mac_r;
        end
      end
      ST_COF2: begin
        cof[ra][rb] <= mac_r;
      end
      ST_DET: begin
        acc <= mac_r;
        if (rb == 2'd2) det <= mac_r;
      end
      ST_GDIV: begin
        result.row          <= ra;
        result.column       <= rb;
        result.result_value <= '0;
        result.singular     <= 1'b1;
        result.last         <= last_ent;
      end
      ST_GWAIT: begin
        result.row          <= ra;
        result.column       <= rb;
        result.result_value <= out_conv(div_q);
        result.singular     <= 1'b0;
        result.last         <= last_ent;
      end
      ST_SMAC: begin
        if (last_term) begin
          acc                 <= '0;
          result.row          <= ra;
          result.column       <= rb;
          result.result_value <= out_conv(mac_r);
          result.singular     <= 1'b0;
          result.last         <= last_ent;
        end else begin
          acc <= mac_r;
        end
      end
      default: begin
        acc <= acc;
      end
    endcase
  end

  `include "elastic_green_tensor_unit_assert.svh"

  `EGT_ASSERT_IMPLY(a_last_frees, clk, rst, strobe && result.last, !busy)
  `EGT_ASSERT_IMPLY(a_mid_busy, clk, rst, strobe && !result.last, busy)
  `EGT_ASSERT_IMPLY(a_singular_zero, clk, rst, strobe && result.singular, result.result_value == '0)
  `EGT_ASSERT_NEXT(a_load_silent, clk, rst, accept && !request.mode[1], !strobe && !busy)

endmodule

>>> bench/egt_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// egt_checker
// Watches the request and result channels of the elastic Green tensor unit,
// keeps its own copy of the stiffness and misfit stores, predicts the nine
// results of each green or stress item and compares them field by field
// ----------------------------------------------------------------------------
module egt_checker
  import egt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  in_item_t    request,
  input  logic        strobe,
  input  out_item_t   result,
  output int          fail_count,
  output int          pending,
  output int          results_checked
);

  localparam longint VMAX = 64'sd2147483647;
  localparam longint VMIN = -64'sd2147483648;

  longint    stiff_copy [C_DEPTH];
  longint    misfit_copy[M_DEPTH];
  out_item_t expected_entries[$];

  // clamp a wide value to the signed 32-bit range
  function automatic longint clip(input logic signed [127:0] v);
    if (v > VMAX) return VMAX;
    if (v < VMIN) return VMIN;
    return longint'(v);
  endfunction

  // fixed point product, floored, saturated
  function automatic longint fmul(input longint a, input longint b);
    logic signed [127:0] wa, wb;
    wa = a;
    wb = b;
    return clip((wa * wb) >>> 16);
  endfunction

  // fixed point quotient, truncated toward zero, saturated
  function automatic longint fdiv(input longint num, input longint den);
    logic signed [127:0] wn, wd;
    wn = num;
    wd = den;
    return clip((wn <<< 16) / wd);
  endfunction

  function automatic longint sadd(input longint a, input longint b);
    logic signed [127:0] wa, wb;
    wa = a;
    wb = b;
    return clip(wa + wb);
  endfunction

  function automatic longint ssub(input longint a, input longint b);
    logic signed [127:0] wa, wb;
    wa = a;
    wb = b;
    return clip(wa - wb);
  endfunction

  function automatic void push_entry(input int k, input longint v, input logic sing);
    out_item_t e;
    e.row          = 2'(k / 3);
    e.column       = 2'(k % 3);
    e.result_value = 32'(v);
    e.singular     = sing;
    e.last         = (k == 8);
    expected_entries.insert(expected_entries.size(), e);
  endfunction

  // acoustic tensor, its cofactors and the inverse
  function automatic void predict_green(input in_item_t it);
    longint n[3];
    longint q[3][3];
    longint cof[3][3];
    longint det, acc, c;
    int     r1, r2, c1, c2;
    n[0] = longint'(it.dir_x);
    n[1] = longint'(it.dir_y);
    n[2] = longint'(it.dir_z);
    for (int i = 0; i < 3; i++)
      for (int p = 0; p < 3; p++) begin
        acc = 0;
        for (int j = 0; j < 3; j++)
          for (int l = 0; l < 3; l++) begin
            c   = stiff_copy[((i * 3 + j) * 3 + l) * 3 + p];
            acc = sadd(acc, fmul(fmul(c, n[j]), n[l]));
          end
        q[i][p] = acc;
      end
    for (int i = 0; i < 3; i++)
      for (int p = 0; p < 3; p++) begin
        r1 = (i + 1) % 3;
        r2 = (i + 2) % 3;
        c1 = (p + 1) % 3;
        c2 = (p + 2) % 3;
        cof[i][p] = ssub(fmul(q[r1][c1], q[r2][c2]), fmul(q[r1][c2], q[r2][c1]));
      end
    det = 0;
    for (int p = 0; p < 3; p++) det = sadd(det, fmul(q[0][p], cof[0][p]));
    for (int k = 0; k < 9; k++)
      push_entry(k, (det == 0) ? 0 : fdiv(cof[k % 3][k / 3], det), det == 0);
  endfunction

  // stiffness contracted with the misfit strain
  function automatic void predict_stress();
    longint acc;
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) begin
        acc = 0;
        for (int k = 0; k < 9; k++)
          acc = sadd(acc, fmul(stiff_copy[(i * 3 + j) * 9 + k], misfit_copy[k]));
        push_entry(i * 3 + j, acc, 1'b0);
      end
  endfunction

  assign pending = expected_entries.size();

  // track accepted items and compare each result strobe
  always @(posedge clk) begin
    out_item_t e;
    if (rst) begin
      foreach (stiff_copy[i]) stiff_copy[i] = 0;
      foreach (misfit_copy[i]) misfit_copy[i] = 0;
      expected_entries.delete();
      fail_count      <= 0;
      results_checked <= 0;
    end else begin
      if (start && !busy) begin
        case (mode_t'(request.mode))
          MODE_LOAD_C: if (request.entry_index < C_DEPTH)
            stiff_copy[request.entry_index] = longint'(request.entry_value);
          MODE_LOAD_M: if (request.entry_index < M_DEPTH)
            misfit_copy[request.entry_index] = longint'(request.entry_value);
          MODE_GREEN:  predict_green(request);
          MODE_STRESS: predict_stress();
          default: ;
        endcase
      end
      if (strobe) begin
        results_checked <= results_checked + 1;
        if (expected_entries.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %p", $time, result);
          fail_count <= fail_count + 1;
        end else begin
          e = expected_entries.pop_front();
          if (result.row !== e.row || result.column !== e.column ||
              result.result_value !== e.result_value ||
              result.singular !== e.singular || result.last !== e.last) begin
            $display("%0t: mismatch, expected %p, actual %p", $time, e, result);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives load, green and stress items into the elastic Green tensor unit in
// bursts with random gaps; the checker predicts and compares every result
// ----------------------------------------------------------------------------
module tb_top;
  import egt_pkg::*;

  logic      clk;
  logic      rst;
  logic      start;
  logic      busy;
  in_item_t  request;
  logic      strobe;
  out_item_t result;
  int        fail_count;
  int        pending;
  int        results_checked;
  int        burst_left;
  int        mode_count[4];

  elastic_green_tensor_unit i_dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .request(request),
    .strobe (strobe),
    .result (result)
  );

  egt_checker i_checker (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .request        (request),
    .strobe         (strobe),
    .result         (result),
    .fail_count     (fail_count),
    .pending        (pending),
    .results_checked(results_checked)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    #20ms;
    $display("timeout");
    $display("== FAIL ==");
    $finish;
  end

  // present one item and hold it until accepted, then maybe pause
  task automatic send(input mode_t m, input logic [6:0] idx, input logic [31:0] val,
                      input logic [31:0] dx, input logic [31:0] dy, input logic [31:0] dz);
    start                <= 1'b1;
    request.mode         <= m;
    request.entry_index  <= idx;
    request.entry_value  <= val;
    request.dir_x        <= dx;
    request.dir_y        <= dy;
    request.dir_z        <= dz;
    @(posedge clk);
    while (busy) @(posedge clk);
    mode_count[m]++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      start <= 1'b0;
      repeat ($urandom_range(1, 20)) @(posedge clk);
      burst_left = $urandom_range(0, 30);
    end
  endtask

  // moderate fixed point value, roughly -4.0 to 4.0
  function automatic logic [31:0] modest();
    return 32'($signed($urandom_range(0, 32'h7FFFF)) - 32'sh40000);
  endfunction

  function automatic logic [31:0] anyval();
    return ($urandom_range(0, 9) == 0) ? $urandom() : modest();
  endfunction

  // isotropic stiffness with random lame constants
  task automatic load_isotropic();
    logic [31:0] lam, mu;
    int          idx, v;
    lam = $urandom_range(0, 32'h30000);
    mu  = $urandom_range(32'h4000, 32'h30000);
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        for (int l = 0; l < 3; l++)
          for (int p = 0; p < 3; p++) begin
            idx = ((i * 3 + j) * 3 + l) * 3 + p;
            v = ((i == j && l == p) ? lam : 0) + ((i == l && j == p) ? mu : 0) +
                ((i == p && j == l) ? mu : 0);
            send(MODE_LOAD_C, 7'(idx), 32'(v), $urandom(), $urandom(), $urandom());
          end
  endtask

  initial begin
    int pick;
    start      <= 1'b0;
    request    <= '0;
    rst        <= 1'b1;
    burst_left = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty stores, extremes, ignored indexes
    send(MODE_GREEN, 7'd0, 32'd0, 32'h00010000, 32'h0, 32'h0);
    send(MODE_STRESS, 7'd0, 32'd0, 32'h0, 32'h0, 32'h0);
    send(MODE_LOAD_C, 7'd0, 32'h7FFFFFFF, 32'h0, 32'h0, 32'h0);
    send(MODE_LOAD_C, 7'd80, 32'h80000000, 32'h0, 32'h0, 32'h0);
    send(MODE_LOAD_C, 7'd81, 32'h12345678, 32'h0, 32'h0, 32'h0);
    send(MODE_LOAD_C, 7'd127, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
    send(MODE_LOAD_M, 7'd0, 32'h7FFFFFFF, 32'h0, 32'h0, 32'h0);
    send(MODE_LOAD_M, 7'd8, 32'h80000000, 32'h0, 32'h0, 32'h0);
    send(MODE_LOAD_M, 7'd9, 32'h00010000, 32'h0, 32'h0, 32'h0);
    send(MODE_LOAD_M, 7'd127, 32'h00010000, 32'h0, 32'h0, 32'h0);
    send(MODE_STRESS, 7'd0, 32'd0, 32'h0, 32'h0, 32'h0);
    send(MODE_GREEN, 7'd0, 32'd0, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF);
    send(MODE_GREEN, 7'd0, 32'd0, 32'h80000000, 32'h80000000, 32'h80000000);
    send(MODE_LOAD_C, 7'd0, 32'h00010000, 32'h0, 32'h0, 32'h0);
    send(MODE_LOAD_C, 7'd80, 32'h00010000, 32'h0, 32'h0, 32'h0);
    send(MODE_GREEN, 7'd0, 32'd0, 32'h00010000, 32'h00010000, 32'h00010000);

    // random: well-formed tensors with random perturbations and queries
    load_isotropic();
    for (int n = 0; n < 153; n++) begin
      pick = $urandom_range(0, 99);
      if (n == 76) load_isotropic();
      else if (pick < 45)
        send(MODE_LOAD_C, ($urandom_range(0, 19) == 0) ? 7'($urandom()) :
             7'($urandom_range(0, 80)), anyval(), $urandom(), $urandom(), $urandom());
      else if (pick < 60)
        send(MODE_LOAD_M, ($urandom_range(0, 9) == 0) ? 7'($urandom()) :
             7'($urandom_range(0, 8)), anyval(), $urandom(), $urandom(), $urandom());
      else if (pick < 85)
        send(MODE_GREEN, 7'($urandom()), $urandom(), anyval(), anyval(), anyval());
      else
        send(MODE_STRESS, 7'($urandom()), $urandom(), $urandom(), $urandom(), $urandom());
    end
    start <= 1'b0;

    // drain
    while (pending != 0) @(posedge clk);
    repeat (1000) @(posedge clk);

    $display("items sent: %0d stiffness loads, %0d misfit loads, %0d green, %0d stress",
             mode_count[MODE_LOAD_C], mode_count[MODE_LOAD_M],
             mode_count[MODE_GREEN], mode_count[MODE_STRESS]);
    $display("results compared: %0d, mismatches: %0d", results_checked, fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+rtl
rtl/egt_pkg.sv
rtl/egt_mac.sv
rtl/egt_div.sv
rtl/elastic_green_tensor_unit.sv
bench/egt_checker.sv
bench/tb_top.sv
